### rtl/tms_pkg.sv
package tms_pkg;

	localparam int DEF_MAX_COLS = 32;
	localparam int DEF_MAX_ROWS = 32;
	localparam int DEF_TILES    = 32;
	localparam int QUEUE_DEPTH  = 4;

	localparam int APB_DW  = 32;
	localparam int PADDR_W = 3;
	localparam int DIM_W   = 6;
	localparam int CELL_W  = 5;
	localparam int PIX_W   = 8;
	localparam int SQ8_W   = 16;
	localparam int SQ_W    = 18;
	localparam int ERR_W   = 28;
	localparam int GAIN_W  = 29;
	localparam int LEFT_W  = 11;

	localparam logic [ERR_W-1:0]  ERR_MAX  = '1;
	localparam logic [GAIN_W-1:0] KEY_TOP  = '1;
	localparam logic [LEFT_W-1:0] LEFT_MAX = '1;

	localparam logic [1:0] MODE_PIX     = 2'd0;
	localparam logic [1:0] MODE_INVAL   = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	localparam logic REG_ACROSS = 1'b0;
	localparam logic REG_DOWN   = 1'b1;

	typedef enum logic [1:0] {OP_PIX, OP_INVAL, OP_RESTART} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [CELL_W-1:0] col;
		logic [CELL_W-1:0] row;
		logic [SQ_W-1:0]   sq;
		logic              cell_end;
		logic              pass_end;
		logic              in_range;
	} op_t;

	typedef struct packed {
		logic [DIM_W:0] across;
		logic [DIM_W:0] down;
	} dims_t;

	typedef enum logic [1:0] {BK_RUN, BK_READ, BK_COMMIT} bk_state_t;

	// register value 0 counts as 1, anything above the array size as the size
	function automatic logic [DIM_W:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W:0] lim);
		logic [DIM_W:0] r;
		r = {1'b0, v};
		if (r == '0) r = (DIM_W+1)'(1);
		if (r > lim) r = lim;
		return r;
	endfunction

	function automatic logic [LEFT_W-1:0] full_count(input logic [DIM_W:0] a,
		input logic [DIM_W:0] d);
		logic [2*DIM_W+1:0] n;
		n = a * d;
		return (n > (2*DIM_W+2)'(LEFT_MAX)) ? LEFT_MAX : n[LEFT_W-1:0];
	endfunction

endpackage

### rtl/tms_fifo.sv
module tms_fifo import tms_pkg::*; #(
	parameter int W     = $bits(op_t),
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/tms_front.sv
module tms_front import tms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dims_t             dims,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        mode,
	input  logic [CELL_W-1:0] cell_col,
	input  logic [CELL_W-1:0] cell_row,
	input  logic [PIX_W-1:0]  tile_red,
	input  logic [PIX_W-1:0]  tile_green,
	input  logic [PIX_W-1:0]  tile_blue,
	input  logic [PIX_W-1:0]  src_red,
	input  logic [PIX_W-1:0]  src_green,
	input  logic [PIX_W-1:0]  src_blue,
	input  logic              last_of_cell,
	input  logic              last_of_pass,
	output op_t               op,
	output logic              op_valid,
	input  logic              op_ready
);

	function automatic logic [SQ8_W-1:0] sq_diff(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		logic [PIX_W-1:0] d;
		d = (a > b) ? a - b : b - a;
		return SQ8_W'(d) * SQ8_W'(d);
	endfunction

	logic              valid_s1;
	op_kind_t          kind_s1;
	logic [CELL_W-1:0] col_s1, row_s1;
	logic [SQ8_W-1:0]  sq_r_s1, sq_g_s1, sq_b_s1;
	logic              cell_end_s1, pass_end_s1, in_range_s1;

	logic              accept, keep, in_range;
	op_kind_t          kind;

	assign in_ready = !valid_s1 || op_ready;
	assign accept   = in_valid && in_ready;
	assign in_range = ({{(DIM_W-4){1'b0}}, cell_col} < dims.across) &&
	                  ({{(DIM_W-4){1'b0}}, cell_row} < dims.down);

	// out-of-range invalidates and the unused mode never reach the queue
	always_comb begin
		keep = 1'b0;
		kind = OP_PIX;
		unique case (mode)
			MODE_PIX: begin
				keep = 1'b1;
				kind = OP_PIX;
			end
			MODE_INVAL: begin
				keep = in_range;
				kind = OP_INVAL;
			end
			MODE_RESTART: begin
				keep = 1'b1;
				kind = OP_RESTART;
			end
			default: begin
				keep = 1'b0;
				kind = OP_PIX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind;
			col_s1      <= cell_col;
			row_s1      <= cell_row;
			sq_r_s1     <= sq_diff(tile_red, src_red);
			sq_g_s1     <= sq_diff(tile_green, src_green);
			sq_b_s1     <= sq_diff(tile_blue, src_blue);
			cell_end_s1 <= last_of_cell;
			pass_end_s1 <= last_of_pass;
			in_range_s1 <= in_range;
		end
	end

	always_comb begin
		op.kind     = kind_s1;
		op.col      = col_s1;
		op.row      = row_s1;
		op.sq       = SQ_W'(sq_r_s1) + SQ_W'(sq_g_s1) + SQ_W'(sq_b_s1);
		op.cell_end = cell_end_s1;
		op.pass_end = pass_end_s1;
		op.in_range = in_range_s1;
	end

	assign op_valid = valid_s1;

endmodule

### rtl/tms_back.sv
module tms_back import tms_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dims_t             dims,
	input  op_t               op,
	input  logic              op_valid,
	output logic              op_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              chosen,
	output logic [CELL_W-1:0] best_col,
	output logic [CELL_W-1:0] best_row,
	output logic [ERR_W-1:0]  best_error,
	output logic              filling
);

	localparam int CELLS    = MAX_COLS * MAX_ROWS;
	localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int IDX_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RST_COLS = (MAX_COLS < DEF_TILES) ? MAX_COLS : DEF_TILES;
	localparam int RST_ROWS = (MAX_ROWS < DEF_TILES) ? MAX_ROWS : DEF_TILES;
	localparam logic [LEFT_W-1:0] LEFT_RST = LEFT_W'(RST_COLS * RST_ROWS);

	function automatic logic [IDX_W-1:0] cell_idx(input logic [CELL_W-1:0] r,
		input logic [CELL_W-1:0] c);
		return IDX_W'(int'(r) * MAX_COLS + int'(c));
	endfunction

	// set flags live one row per word; a row whose valid flop is low reads as all unset
	logic [MAX_COLS-1:0] set_mem [MAX_ROWS];
	logic [ERR_W-1:0]    err_mem [CELLS];
	logic [MAX_COLS-1:0] set_rdata_q;
	logic [ERR_W-1:0]    err_rdata_q;
	logic [MAX_ROWS-1:0] row_valid_q;

	logic [ROW_W-1:0]    set_raddr, set_waddr;
	logic [MAX_COLS-1:0] set_wdata;
	logic                set_we;
	logic [IDX_W-1:0]    err_raddr, err_waddr;
	logic                err_we;

	bk_state_t           state_q, state_d;
	logic                e_valid_s2;
	op_t                 e_op_s2;

	logic [ERR_W-1:0]    accum_q;
	logic [LEFT_W-1:0]   unset_left_q;
	logic                cand_found_q;
	logic [CELL_W-1:0]   cand_col_q, cand_row_q;
	logic [ERR_W-1:0]    cand_error_q;
	logic [GAIN_W-1:0]   cand_gain_q;

	logic                fwd_valid_q;
	logic [ROW_W-1:0]    fwd_row_q;
	logic [MAX_COLS-1:0] fwd_data_q;

	logic                out_valid_q, chosen_q, filling_q;
	logic [CELL_W-1:0]   best_col_q, best_row_q;
	logic [ERR_W-1:0]    best_error_q;

	logic [COL_W-1:0]    e_col, c_col;
	logic [ROW_W-1:0]    e_row, c_row;
	logic [MAX_COLS-1:0] e_set_row, c_set_row;
	logic                e_is_set, c_was_set, fwd_hit;
	logic [GAIN_W-1:0]   sum_ext, key;
	logic [ERR_W-1:0]    acc_sum;
	logic                filling_now, judge, take, e_pass_end;
	logic                inval_we, commit_go;

	// item in the execute stage
	assign e_col      = COL_W'(e_op_s2.col);
	assign e_row      = ROW_W'(e_op_s2.row);
	assign fwd_hit    = fwd_valid_q && (fwd_row_q == e_row);
	assign e_set_row  = row_valid_q[e_row] ? (fwd_hit ? fwd_data_q : set_rdata_q) : '0;
	assign e_is_set   = e_set_row[e_col];
	assign e_pass_end = e_valid_s2 && (e_op_s2.kind == OP_PIX) && e_op_s2.pass_end;

	assign sum_ext     = {1'b0, accum_q} + GAIN_W'(e_op_s2.sq);
	assign acc_sum     = sum_ext[ERR_W] ? ERR_MAX : sum_ext[ERR_W-1:0];
	assign filling_now = (unset_left_q != '0);

	// an unset cell's key sits above every set cell's key
	assign key = e_is_set ?
		((err_rdata_q > acc_sum) ? {1'b0, err_rdata_q - acc_sum} : '0) :
		KEY_TOP - {1'b0, acc_sum};

	assign judge = e_valid_s2 && (e_op_s2.kind == OP_PIX) && e_op_s2.cell_end &&
	               e_op_s2.in_range;
	assign take  = judge && (filling_now ?
		(!e_is_set && (!cand_found_q || (acc_sum < cand_error_q))) :
		(key > cand_gain_q));

	// candidate commit at pass end
	assign c_col     = COL_W'(cand_col_q);
	assign c_row     = ROW_W'(cand_row_q);
	assign c_set_row = row_valid_q[c_row] ? set_rdata_q : '0;
	assign c_was_set = c_set_row[c_col];
	assign commit_go = (state_q == BK_COMMIT) && (!out_valid_q || out_ready);
	assign inval_we  = e_valid_s2 && (e_op_s2.kind == OP_INVAL);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_RUN:    if (e_pass_end) state_d = BK_READ;
			BK_READ:   state_d = BK_COMMIT;
			BK_COMMIT: if (commit_go) state_d = BK_RUN;
			default:   state_d = BK_RUN;
		endcase
	end

	always_comb begin
		op_ready  = (state_q == BK_RUN) && !e_pass_end;
		set_raddr = (state_q == BK_RUN) ? ROW_W'(op.row) : c_row;
		err_raddr = cell_idx(op.row, op.col);
		set_we    = inval_we || (commit_go && cand_found_q);
		set_waddr = inval_we ? e_row : c_row;
		set_wdata = inval_we ? (e_set_row & ~(MAX_COLS'(1) << e_col)) :
		                       (c_set_row | (MAX_COLS'(1) << c_col));
		err_we    = commit_go && cand_found_q;
		err_waddr = cell_idx(cand_row_q, cand_col_q);
	end

	always_ff @(posedge clk) begin
		if (set_we) begin
			set_mem[set_waddr] <= set_wdata;
		end
		set_rdata_q <= set_mem[set_raddr];
	end

	always_ff @(posedge clk) begin
		if (err_we) begin
			err_mem[err_waddr] <= cand_error_q;
		end
		err_rdata_q <= err_mem[err_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_RUN;
			e_valid_s2   <= 1'b0;
			fwd_valid_q  <= 1'b0;
			row_valid_q  <= '0;
			unset_left_q <= LEFT_RST;
			accum_q      <= '0;
			cand_found_q <= 1'b0;
			cand_col_q   <= '0;
			cand_row_q   <= '0;
			cand_error_q <= '0;
			cand_gain_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			e_valid_s2  <= op_ready && op_valid;
			fwd_valid_q <= inval_we;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (e_valid_s2) begin
				unique case (e_op_s2.kind)
					OP_PIX: begin
						if (take) begin
							cand_found_q <= 1'b1;
							cand_col_q   <= e_op_s2.col;
							cand_row_q   <= e_op_s2.row;
							cand_error_q <= acc_sum;
							if (!filling_now) cand_gain_q <= key;
						end
						accum_q <= (e_op_s2.cell_end || e_op_s2.pass_end) ? '0 : acc_sum;
					end
					OP_INVAL: begin
						row_valid_q[e_row] <= 1'b1;
					end
					OP_RESTART: begin
						row_valid_q  <= '0;
						unset_left_q <= full_count(dims.across, dims.down);
						accum_q      <= '0;
						cand_found_q <= 1'b0;
						cand_col_q   <= '0;
						cand_row_q   <= '0;
						cand_error_q <= '0;
						cand_gain_q  <= '0;
					end
					default: ;
				endcase
			end
			if (commit_go) begin
				out_valid_q <= 1'b1;
				if (cand_found_q) begin
					row_valid_q[c_row] <= 1'b1;
					if (!c_was_set && filling_now) unset_left_q <= unset_left_q - LEFT_W'(1);
				end
				cand_found_q <= 1'b0;
				cand_col_q   <= '0;
				cand_row_q   <= '0;
				cand_error_q <= '0;
				cand_gain_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_ready && op_valid) begin
			e_op_s2 <= op;
		end
		if (inval_we) begin
			fwd_row_q  <= e_row;
			fwd_data_q <= set_wdata;
		end
		if (commit_go) begin
			chosen_q     <= cand_found_q;
			best_col_q   <= cand_col_q;
			best_row_q   <= cand_row_q;
			best_error_q <= cand_error_q;
			filling_q    <= filling_now;
		end
	end

	assign out_valid  = out_valid_q;
	assign chosen     = chosen_q;
	assign best_col   = best_col_q;
	assign best_row   = best_row_q;
	assign best_error = best_error_q;
	assign filling    = filling_q;

	a_exec_idle_in_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != BK_RUN |-> !e_valid_s2)
		else $error("execute stage busy during pass-end commit");

	a_pass_end_reads: assert property (@(posedge clk) disable iff (!arst_n)
		e_pass_end |=> state_q == BK_READ)
		else $error("pass end did not start the commit read");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == BK_COMMIT)
		else $error("result raised outside commit");

	a_left_changes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != BK_COMMIT && !(e_valid_s2 && e_op_s2.kind == OP_RESTART)
		|=> $stable(unset_left_q))
		else $error("unset count moved without commit or restart");

endmodule

### rtl/tile_match_selector.sv
// Sum-of-squared-differences tile matcher.
// Input channel (in_valid/in_ready): one item per cycle while ready. Mode 0
// carries a pixel pair of the captured tile and the source cell, with cell and
// pass end marks; mode 1 invalidates one cell, mode 2 unsets every cell again.
// Output channel (out_valid/out_ready): one result per pass, on the item
// carrying last_of_pass, naming the chosen cell and its new stored error.
// Configuration over APB: tiles_across at 0x0, tiles_down at 0x4; write only
// while the block is idle.
// Throughput: one item per cycle while in_ready is high. The front squares and
// sums the channel differences, a four-entry queue feeds the back, which
// accumulates and judges a cell at its end against the error and set-flag
// memories. At each pass end the back end takes no items during the read and
// write of the winner's row in the set-flag memory; the queue absorbs this.
// A pass-end item passes the front stage, queue, execute stage, read and
// commit states to the result register, later if the previous result waits.
// A stalled receiver holds the result register; the queue keeps filling and
// in_ready falls only once it and the front stage are full.
// Reset: all cells unset at once through one valid flop per row of the set
// memory, no clearing pass; registers go to 32 by 32.
module tile_match_selector import tms_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [CELL_W-1:0]  cell_col,
	input  logic [CELL_W-1:0]  cell_row,
	input  logic [PIX_W-1:0]   tile_red,
	input  logic [PIX_W-1:0]   tile_green,
	input  logic [PIX_W-1:0]   tile_blue,
	input  logic [PIX_W-1:0]   src_red,
	input  logic [PIX_W-1:0]   src_green,
	input  logic [PIX_W-1:0]   src_blue,
	input  logic               last_of_cell,
	input  logic               last_of_pass,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               chosen,
	output logic [CELL_W-1:0]  best_col,
	output logic [CELL_W-1:0]  best_row,
	output logic [ERR_W-1:0]   best_error,
	output logic               filling
);

	logic [DIM_W-1:0] across_q, down_q;
	dims_t            dims;
	op_t              front_op, queue_op;
	logic [$bits(op_t)-1:0] queue_bits;
	logic             front_valid, front_ready, queue_valid, queue_ready;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			across_q <= DIM_W'(DEF_TILES);
			down_q   <= DIM_W'(DEF_TILES);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_ACROSS: across_q <= pwdata[DIM_W-1:0];
				REG_DOWN:   down_q   <= pwdata[DIM_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ACROSS: prdata = {{(APB_DW-DIM_W){1'b0}}, across_q};
			REG_DOWN:   prdata = {{(APB_DW-DIM_W){1'b0}}, down_q};
		endcase
	end

	assign dims.across = clamp_dim(across_q, (DIM_W+1)'(MAX_COLS));
	assign dims.down   = clamp_dim(down_q, (DIM_W+1)'(MAX_ROWS));

	tms_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.dims         (dims),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.cell_col     (cell_col),
		.cell_row     (cell_row),
		.tile_red     (tile_red),
		.tile_green   (tile_green),
		.tile_blue    (tile_blue),
		.src_red      (src_red),
		.src_green    (src_green),
		.src_blue     (src_blue),
		.last_of_cell (last_of_cell),
		.last_of_pass (last_of_pass),
		.op           (front_op),
		.op_valid     (front_valid),
		.op_ready     (front_ready)
	);

	tms_fifo #(
		.W     ($bits(op_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_op),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_bits)
	);

	assign queue_op = op_t'(queue_bits);

	tms_back #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.dims       (dims),
		.op         (queue_op),
		.op_valid   (queue_valid),
		.op_ready   (queue_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.chosen     (chosen),
		.best_col   (best_col),
		.best_row   (best_row),
		.best_error (best_error),
		.filling    (filling)
	);

endmodule

### verif/tile_match_selector_tb.sv
module tile_match_selector_tb import tms_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int N_CELLS = DEF_MAX_COLS * DEF_MAX_ROWS;
	localparam int SETTLE_CYCLES = 24;
	localparam int STUCK_LIMIT = 1000;
	localparam int N_PHASES = 10;
	localparam int PHASE_ITEMS = 160;

	typedef struct packed {
		logic [1:0]        mode;
		logic [CELL_W-1:0] col;
		logic [CELL_W-1:0] row;
		logic [23:0]       tile;
		logic [23:0]       src;
		logic              cell_end;
		logic              pass_end;
	} pair_item_t;

	typedef struct packed {
		logic              chosen;
		logic [CELL_W-1:0] col;
		logic [CELL_W-1:0] row;
		logic [ERR_W-1:0]  err;
		logic              fill;
	} match_res_t;

	typedef struct packed {
		pair_item_t item;
		logic [11:0] rep;
		logic        fixed;
		match_res_t  res;
	} step_row_t;

	localparam match_res_t NO_RESULT = '0;
	localparam int N_STEPS = 17;

	// directed part, run at the reset setting of 32 by 32
	localparam step_row_t STEPS [N_STEPS] = '{
		'{'{MODE_PIX, 5'd0, 5'd0, 24'h000000, 24'h000000, 1'b1, 1'b1}, 12'd1, 1'b1,
			'{1'b1, 5'd0, 5'd0, 28'd0, 1'b1}},
		'{'{MODE_PIX, 5'd1, 5'd0, 24'hFFFFFF, 24'h000000, 1'b1, 1'b1}, 12'd1, 1'b1,
			'{1'b1, 5'd1, 5'd0, 28'd195075, 1'b1}},
		// pass end with no judged cell
		'{'{MODE_PIX, 5'd31, 5'd31, 24'h000000, 24'hFFFFFF, 1'b0, 1'b1}, 12'd1, 1'b1,
			'{1'b0, 5'd0, 5'd0, 28'd0, 1'b1}},
		'{'{MODE_NONE, 5'd5, 5'd5, 24'hABCDEF, 24'h123456, 1'b1, 1'b1}, 12'd1, 1'b0,
			NO_RESULT},
		'{'{MODE_INVAL, 5'd0, 5'd0, 24'h000000, 24'h000000, 1'b0, 1'b0}, 12'd1, 1'b0,
			NO_RESULT},
		'{'{MODE_INVAL, 5'd31, 5'd31, 24'h000000, 24'h000000, 1'b0, 1'b0}, 12'd1, 1'b0,
			NO_RESULT},
		'{'{MODE_PIX, 5'd31, 5'd31, 24'h123456, 24'h654321, 1'b1, 1'b0}, 12'd1, 1'b0,
			NO_RESULT},
		'{'{MODE_PIX, 5'd0, 5'd0, 24'h808080, 24'h808080, 1'b1, 1'b1}, 12'd1, 1'b1,
			'{1'b1, 5'd0, 5'd0, 28'd0, 1'b1}},
		// long full-contrast cell drives the sum into saturation
		'{'{MODE_PIX, 5'd2, 5'd0, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0}, 12'd1400, 1'b0,
			NO_RESULT},
		'{'{MODE_PIX, 5'd2, 5'd0, 24'hFFFFFF, 24'h000000, 1'b1, 1'b1}, 12'd1, 1'b1,
			'{1'b1, 5'd2, 5'd0, 28'hFFFFFFF, 1'b1}},
		'{'{MODE_PIX, 5'd3, 5'd1, 24'h0A141E, 24'h1E140A, 1'b1, 1'b0}, 12'd1, 1'b0,
			NO_RESULT},
		'{'{MODE_PIX, 5'd4, 5'd1, 24'h00FF00, 24'hFF00FF, 1'b1, 1'b1}, 12'd1, 1'b0,
			NO_RESULT},
		'{'{MODE_INVAL, 5'd1, 5'd0, 24'h000000, 24'h000000, 1'b0, 1'b0}, 12'd1, 1'b0,
			NO_RESULT},
		'{'{MODE_RESTART, 5'd0, 5'd0, 24'h000000, 24'h000000, 1'b0, 1'b0}, 12'd1, 1'b0,
			NO_RESULT},
		'{'{MODE_PIX, 5'd31, 5'd0, 24'h010203, 24'h030201, 1'b1, 1'b1}, 12'd1, 1'b1,
			'{1'b1, 5'd31, 5'd0, 28'd8, 1'b1}},
		'{'{MODE_PIX, 5'd0, 5'd31, 24'hFF00FF, 24'h00FF00, 1'b1, 1'b0}, 12'd1, 1'b0,
			NO_RESULT},
		'{'{MODE_RESTART, 5'd0, 5'd0, 24'h000000, 24'h000000, 1'b0, 1'b0}, 12'd1, 1'b0,
			NO_RESULT}
	};

	localparam logic [DIM_W-1:0] ACROSS_SEQ [N_PHASES] =
		'{6'd0, 6'd1, 6'd2, 6'd63, 6'd1, 6'd3, 6'd2, 6'd4, 6'd32, 6'd33};
	localparam logic [DIM_W-1:0] DOWN_SEQ [N_PHASES] =
		'{6'd0, 6'd2, 6'd2, 6'd1, 6'd63, 6'd2, 6'd3, 6'd1, 6'd32, 6'd3};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [APB_DW-1:0]  pwdata = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         mode = MODE_PIX;
	logic [CELL_W-1:0]  cell_col = '0;
	logic [CELL_W-1:0]  cell_row = '0;
	logic [PIX_W-1:0]   tile_red = '0;
	logic [PIX_W-1:0]   tile_green = '0;
	logic [PIX_W-1:0]   tile_blue = '0;
	logic [PIX_W-1:0]   src_red = '0;
	logic [PIX_W-1:0]   src_green = '0;
	logic [PIX_W-1:0]   src_blue = '0;
	logic               last_of_cell = 1'b0;
	logic               last_of_pass = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               chosen;
	logic [CELL_W-1:0]  best_col;
	logic [CELL_W-1:0]  best_row;
	logic [ERR_W-1:0]   best_error;
	logic               filling;

	tile_match_selector u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.cell_col     (cell_col),
		.cell_row     (cell_row),
		.tile_red     (tile_red),
		.tile_green   (tile_green),
		.tile_blue    (tile_blue),
		.src_red      (src_red),
		.src_green    (src_green),
		.src_blue     (src_blue),
		.last_of_cell (last_of_cell),
		.last_of_pass (last_of_pass),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chosen       (chosen),
		.best_col     (best_col),
		.best_row     (best_row),
		.best_error   (best_error),
		.filling      (filling)
	);

	always #1 clk = ~clk;

	// matcher state mirrored in the bench
	logic [ERR_W-1:0]  tab_err [N_CELLS];
	bit                tab_set [N_CELLS];
	int unsigned       unset_cnt;
	logic [ERR_W-1:0]  ssd_acc;
	logic [CELL_W-1:0] lead_col;
	logic [CELL_W-1:0] lead_row;
	logic [ERR_W-1:0]  lead_err;
	logic [GAIN_W-1:0] lead_gain;
	bit                lead_ok;
	logic [DIM_W-1:0]  reg_across = 6'd32;
	logic [DIM_W-1:0]  reg_down = 6'd32;

	match_res_t pending_matches [$];
	int n_errs = 0;
	int n_sent = 0;
	int burst_left = 0;
	int stuck = 0;

	function automatic int unsigned dim_in_use(logic [DIM_W-1:0] v, int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic bit cell_in_use(logic [CELL_W-1:0] c, logic [CELL_W-1:0] r);
		return c < dim_in_use(reg_across, DEF_MAX_COLS) &&
			r < dim_in_use(reg_down, DEF_MAX_ROWS);
	endfunction

	function automatic int unsigned cells_in_use();
		int unsigned n;
		n = dim_in_use(reg_across, DEF_MAX_COLS) * dim_in_use(reg_down, DEF_MAX_ROWS);
		return (n > LEFT_MAX) ? LEFT_MAX : n;
	endfunction

	function automatic int unsigned sq_dist(logic [7:0] a, logic [7:0] b);
		int unsigned d;
		d = (a > b) ? a - b : b - a;
		return d * d;
	endfunction

	function automatic void drop_lead();
		lead_col = '0;
		lead_row = '0;
		lead_err = '0;
		lead_gain = '0;
		lead_ok = 1'b0;
	endfunction

	function automatic void grade_cell(logic [CELL_W-1:0] c, logic [CELL_W-1:0] r);
		int unsigned idx;
		logic [GAIN_W-1:0] key;
		if (!cell_in_use(c, r))
			return;
		idx = int'(r) * DEF_MAX_COLS + int'(c);
		if (unset_cnt > 0) begin
			if (tab_set[idx])
				return;
			if (!lead_ok || ssd_acc < lead_err) begin
				lead_ok = 1'b1;
				lead_col = c;
				lead_row = r;
				lead_err = ssd_acc;
			end
		end else begin
			// an unset cell always outranks a set one
			if (tab_set[idx])
				key = (tab_err[idx] > ssd_acc) ? GAIN_W'(tab_err[idx] - ssd_acc) : '0;
			else
				key = KEY_TOP - GAIN_W'(ssd_acc);
			if (key > lead_gain) begin
				lead_ok = 1'b1;
				lead_gain = key;
				lead_col = c;
				lead_row = r;
				lead_err = ssd_acc;
			end
		end
	endfunction

	function automatic bit match_step(input pair_item_t it, output match_res_t r);
		int unsigned s;
		int unsigned idx;
		logic fill;
		r = '0;
		case (it.mode)
			MODE_INVAL: begin
				if (cell_in_use(it.col, it.row))
					tab_set[int'(it.row) * DEF_MAX_COLS + int'(it.col)] = 1'b0;
				return 1'b0;
			end
			MODE_RESTART: begin
				tab_set = '{default: 1'b0};
				unset_cnt = cells_in_use();
				ssd_acc = '0;
				drop_lead();
				return 1'b0;
			end
			MODE_PIX: ;
			default: return 1'b0;
		endcase
		s = sq_dist(it.tile[23:16], it.src[23:16]) + sq_dist(it.tile[15:8], it.src[15:8]) +
			sq_dist(it.tile[7:0], it.src[7:0]);
		ssd_acc = (ERR_MAX - ssd_acc < s) ? ERR_MAX : ssd_acc + s;
		if (it.cell_end)
			grade_cell(it.col, it.row);
		if (it.cell_end || it.pass_end)
			ssd_acc = '0;
		if (!it.pass_end)
			return 1'b0;
		fill = unset_cnt > 0;
		if (lead_ok) begin
			idx = int'(lead_row) * DEF_MAX_COLS + int'(lead_col);
			if (!tab_set[idx] && unset_cnt > 0)
				unset_cnt--;
			tab_set[idx] = 1'b1;
			tab_err[idx] = lead_err;
			r.chosen = 1'b1;
			r.col = lead_col;
			r.row = lead_row;
			r.err = lead_err;
		end
		r.fill = fill;
		drop_lead();
		return 1'b1;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errs++;
		end
	endfunction

	task automatic send(input pair_item_t it, input bit fixed_ok, input match_res_t fixed);
		match_res_t r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= it.mode;
		cell_col <= it.col;
		cell_row <= it.row;
		tile_red <= it.tile[23:16];
		tile_green <= it.tile[15:8];
		tile_blue <= it.tile[7:0];
		src_red <= it.src[23:16];
		src_green <= it.src[15:8];
		src_blue <= it.src[7:0];
		last_of_cell <= it.cell_end;
		last_of_pass <= it.pass_end;
		do @(posedge clk); while (!in_ready);
		if (it.mode != MODE_NONE)
			n_sent++;
		if (match_step(it, r))
			pending_matches.push_back(fixed_ok ? fixed : r);
	endtask

	// drop valid and hold off until every result is out and the back end is quiet
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_matches.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic reg_idx, input logic [DIM_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({reg_idx, 2'b00});
		pwdata <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (reg_idx == REG_ACROSS)
			reg_across = val;
		else
			reg_down = val;
	endtask

	function automatic void pick_cell(output logic [CELL_W-1:0] c,
		output logic [CELL_W-1:0] r, input int in_use_pct);
		if ($urandom_range(0, 99) < in_use_pct) begin
			c = $urandom_range(0, dim_in_use(reg_across, DEF_MAX_COLS) - 1);
			r = $urandom_range(0, dim_in_use(reg_down, DEF_MAX_ROWS) - 1);
		end else begin
			c = $urandom_range(0, 31);
			r = $urandom_range(0, 31);
		end
	endfunction

	// close colours give ties and small gains, full random gives the extremes
	function automatic void paint(inout pair_item_t it);
		logic [23:0] mask;
		case ($urandom_range(0, 4))
			0: mask = 24'h000000;
			1: mask = 24'h030303;
			2: mask = 24'h0F0F0F;
			default: mask = 24'hFFFFFF;
		endcase
		it.tile = 24'($urandom);
		it.src = it.tile ^ (24'($urandom) & mask);
	endfunction

	task automatic noise();
		pair_item_t it;
		logic [63:0] raw;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			raw = {$urandom, $urandom};
			it = raw[$bits(pair_item_t)-1:0];
			it.mode = MODE_INVAL;
			pick_cell(it.col, it.row, 75);
			send(it, 1'b0, NO_RESULT);
		end else if (pick < 7) begin
			raw = {$urandom, $urandom};
			it = raw[$bits(pair_item_t)-1:0];
			it.mode = MODE_NONE;
			send(it, 1'b0, NO_RESULT);
		end else if (pick == 7) begin
			it = '0;
			it.mode = MODE_RESTART;
			send(it, 1'b0, NO_RESULT);
		end
	endtask

	task automatic run_pass();
		pair_item_t it;
		int n_cells;
		int n_px;
		bit tail;
		logic [CELL_W-1:0] c;
		logic [CELL_W-1:0] r;
		n_cells = $urandom_range(1, 4);
		tail = $urandom_range(0, 9) == 0;
		for (int k = 0; k < n_cells; k++) begin
			pick_cell(c, r, 88);
			n_px = $urandom_range(1, 3);
			for (int p = 0; p < n_px; p++) begin
				noise();
				it.mode = MODE_PIX;
				it.col = c;
				it.row = r;
				paint(it);
				it.cell_end = p == n_px - 1;
				it.pass_end = !tail && k == n_cells - 1 && p == n_px - 1;
				send(it, 1'b0, NO_RESULT);
			end
		end
		if (tail) begin
			// pass closes on a partial cell
			it.mode = MODE_PIX;
			pick_cell(it.col, it.row, 88);
			paint(it);
			it.cell_end = 1'b0;
			it.pass_end = 1'b1;
			send(it, 1'b0, NO_RESULT);
		end
		if ($urandom_range(0, 29) == 0)
			settle();
	endtask

	initial begin : receiver
		int style;
		int span;
		int hold;
		bit lvl;
		hold = 0;
		lvl = 1'b1;
		forever begin
			style = $urandom_range(0, 2);
			span = $urandom_range(10, 60);
			repeat (span) begin
				@(posedge clk);
				case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: begin
						if (hold == 0) begin
							lvl = !lvl;
							hold = lvl ? $urandom_range(1, 4) : $urandom_range(1, 12);
						end
						hold--;
						out_ready <= lvl;
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		match_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_matches.size() == 0) begin
				$error("result with nothing expected: col %0d row %0d error %0d",
					best_col, best_row, best_error);
				n_errs++;
			end else begin
				want = pending_matches.pop_front();
				check_field("chosen", want.chosen, chosen);
				check_field("best_col", want.col, best_col);
				check_field("best_row", want.row, best_row);
				check_field("best_error", want.err, best_error);
				check_field("filling", want.fill, filling);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			stuck = 0;
		else begin
			stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int base;
		pair_item_t it;
		tab_err = '{default: '0};
		tab_set = '{default: 1'b0};
		unset_cnt = cells_in_use();
		ssd_acc = '0;
		drop_lead();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_STEPS; i++)
			for (int k = 0; k < STEPS[i].rep; k++)
				send(STEPS[i].item, STEPS[i].fixed, STEPS[i].res);

		base = n_sent;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			reg_write(REG_ACROSS, ACROSS_SEQ[ph]);
			reg_write(REG_DOWN, DOWN_SEQ[ph]);
			// now and then keep the old unset count across a new setting
			if (ph == 0 || $urandom_range(0, 3) != 0) begin
				it = '0;
				it.mode = MODE_RESTART;
				send(it, 1'b0, NO_RESULT);
			end
			while (n_sent < base + (ph + 1) * PHASE_ITEMS)
				run_pass();
		end

		settle();
		if (n_errs == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### filelist.f
rtl/tms_pkg.sv
rtl/tms_fifo.sv
rtl/tms_front.sv
rtl/tms_back.sv
rtl/tile_match_selector.sv
verif/tile_match_selector_tb.sv
